// ----- rtl/bgrft_pkg.sv -----
// Shared constants, types and helper functions of the bit grid transform block.
`default_nettype none
package bgrft_pkg;

  localparam int unsigned MaxRows   = 8;
  localparam int unsigned MaxCols   = 8;
  localparam int unsigned GridDepth = MaxRows * MaxCols;
  localparam int unsigned AddrW     = $clog2(GridDepth);
  localparam int unsigned CountW    = $clog2(GridDepth + 1);
  localparam int unsigned DimW      = 4;
  localparam int unsigned CoordW    = 3;
  localparam int unsigned ModeW     = 3;
  localparam int unsigned CfgIdxW   = 2;
  localparam int unsigned CfgDataW  = 4;
  localparam int unsigned CodeW     = 2;

  // Reciprocal used to split a fill count into row and column.
  localparam int unsigned RecipShift = 9;
  localparam int unsigned RecipW     = RecipShift + 1;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_ROWS = 2'd0,
    CFG_COLS = 2'd1,
    CFG_MODE = 2'd2
  } cfg_idx_e;

  typedef enum logic [ModeW-1:0] {
    MODE_FLIP      = 3'd0,
    MODE_MIRROR    = 3'd1,
    MODE_TRANSPOSE = 3'd2,
    MODE_ROT90     = 3'd3,
    MODE_ROT180    = 3'd4,
    MODE_ROT270    = 3'd5
  } mode_e;

  typedef enum logic [1:0] {
    ST_LOAD = 2'b01,
    ST_EMIT = 2'b10
  } state_e;

  typedef struct packed {
    logic [CoordW-1:0] row;
    logic [CoordW-1:0] col;
  } pos_t;

  // Clamp a configured dimension into 1..lim.
  function automatic logic [DimW-1:0] eff_dim(logic [DimW-1:0] v, logic [DimW-1:0] lim);
    logic [DimW-1:0] res;
    if (v == '0) begin
      res = DimW'(1);
    end else if (v > lim) begin
      res = lim;
    end else begin
      res = v;
    end
    return res;
  endfunction

  // floor(2^RecipShift / d) for the legal column counts.
  function automatic logic [RecipW-1:0] recip(logic [DimW-1:0] d);
    logic [RecipW-1:0] res;
    case (d)
      4'd1:    res = RecipW'(512);
      4'd2:    res = RecipW'(256);
      4'd3:    res = RecipW'(170);
      4'd4:    res = RecipW'(128);
      4'd5:    res = RecipW'(102);
      4'd6:    res = RecipW'(85);
      4'd7:    res = RecipW'(73);
      4'd8:    res = RecipW'(64);
      default: res = RecipW'(512);
    endcase
    return res;
  endfunction

endpackage
`default_nettype wire

// ----- rtl/bgrft_divmod.sv -----
// Splits the fill count into row and column for the current column count.
`default_nettype none
module bgrft_divmod (
  input  wire logic [bgrft_pkg::AddrW-1:0] count_i,
  input  wire logic [bgrft_pkg::DimW-1:0]  cols_i,
  output bgrft_pkg::pos_t                  pos_o
);

  localparam int unsigned ProdW = bgrft_pkg::AddrW + bgrft_pkg::RecipW;
  localparam int unsigned QuotW = ProdW - bgrft_pkg::RecipShift;
  localparam int unsigned QcW   = QuotW + bgrft_pkg::DimW;

  logic [ProdW-1:0] prod;
  logic [QuotW-1:0] q_est;
  logic [QcW-1:0]   qc;
  logic [QcW-1:0]   rem_est;
  logic [QuotW-1:0] quot;
  logic [QcW-1:0]   rem;

  always_comb begin
    prod    = ProdW'(count_i) * ProdW'(bgrft_pkg::recip(cols_i));
    q_est   = prod[ProdW-1:bgrft_pkg::RecipShift];
    qc      = QcW'(q_est) * QcW'(cols_i);
    rem_est = QcW'(count_i) - qc;
    // estimate is low by at most one
    if (rem_est >= QcW'(cols_i)) begin
      quot = q_est + QuotW'(1);
      rem  = rem_est - QcW'(cols_i);
    end else begin
      quot = q_est;
      rem  = rem_est;
    end
    pos_o.row = quot[bgrft_pkg::CoordW-1:0];
    pos_o.col = rem[bgrft_pkg::CoordW-1:0];
  end

endmodule
`default_nettype wire

// ----- rtl/bit_grid_rotate_flip_transpose.sv -----
// Top level: grid load, transform sequencer and grid memory.
`default_nettype none
// Takes one cell per cycle while loading. After the beat flagged last_cell the
// input stalls, and results are fetched through the registered memory read;
// results then follow one per cycle while the sink does not stall, paced by the
// single read port of the grid memory. Loading resumes the cycle after the final
// result is taken. Unloaded cells read as zero through the fill count, so there
// is no clearing pass.
module bit_grid_rotate_flip_transpose (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              cfg_valid_i,
  output      logic                              cfg_ready_o,
  input  wire logic [bgrft_pkg::CfgIdxW-1:0]     cfg_index_i,
  input  wire logic [bgrft_pkg::CfgDataW-1:0]    cfg_data_i,
  input  wire logic                              in_valid_i,
  output      logic                              in_stall_o,
  input  wire logic [bgrft_pkg::CodeW-1:0]       cell_code_i,
  input  wire logic                              last_cell_i,
  output      logic                              out_valid_o,
  input  wire logic                              out_stall_i,
  output      logic                              out_bit_o,
  output      logic [bgrft_pkg::CoordW-1:0]      out_row_o,
  output      logic [bgrft_pkg::CoordW-1:0]      out_col_o,
  output      logic [bgrft_pkg::CoordW-1:0]      center_x_o,
  output      logic [bgrft_pkg::CoordW-1:0]      center_y_o,
  output      logic                              last_result_o
);

  localparam int unsigned DimW   = bgrft_pkg::DimW;
  localparam int unsigned CoordW = bgrft_pkg::CoordW;
  localparam int unsigned AddrW  = bgrft_pkg::AddrW;
  localparam int unsigned CountW = bgrft_pkg::CountW;
  localparam int unsigned IdxW   = 2 * DimW;

  bgrft_pkg::state_e state_q, state_d;

  logic [DimW-1:0]             rows_q, cols_q;
  logic [bgrft_pkg::ModeW-1:0] mode_q;
  logic [CountW-1:0]           load_cnt_q, load_cnt_d;
  logic [CoordW-1:0]           cen_row_q, cen_row_d, cen_col_q, cen_col_d;
  logic [CoordW-1:0]           r_q, r_d, c_q, c_d;
  logic                        more_q, more_d;
  logic                        out_valid_q, out_valid_d;
  logic [CoordW-1:0]           out_row_q, out_col_q;
  logic                        out_last_q, out_hit_q;
  logic                        rdata_q;

  logic                        mem [bgrft_pkg::GridDepth];

  logic [DimW-1:0]   eff_rows, eff_cols, o_rows, o_cols;
  logic [IdxW-1:0]   total;
  logic              in_take, load_wr, fetch, out_take, last_col, last_row, final_cell;
  logic              swap;
  logic [DimW-1:0]   src_r, src_c;
  logic [IdxW-1:0]   src_idx;
  logic              src_hit;
  logic [CoordW-1:0] cen_x, cen_y, rows3, cols3;
  bgrft_pkg::pos_t   ld_pos;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rows_q <= DimW'(1);
      cols_q <= DimW'(1);
      mode_q <= bgrft_pkg::MODE_FLIP;
    end else if (cfg_valid_i) begin
      case (bgrft_pkg::cfg_idx_e'(cfg_index_i))
        bgrft_pkg::CFG_ROWS: rows_q <= cfg_data_i;
        bgrft_pkg::CFG_COLS: cols_q <= cfg_data_i;
        bgrft_pkg::CFG_MODE: mode_q <= cfg_data_i[bgrft_pkg::ModeW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    eff_rows = bgrft_pkg::eff_dim(rows_q, DimW'(bgrft_pkg::MaxRows));
    eff_cols = bgrft_pkg::eff_dim(cols_q, DimW'(bgrft_pkg::MaxCols));
    total    = IdxW'(eff_rows) * IdxW'(eff_cols);
  end

  assign in_stall_o = (state_q != bgrft_pkg::ST_LOAD);
  assign in_take    = in_valid_i && !in_stall_o;
  assign load_wr    = in_take && (IdxW'(load_cnt_q) < total);

  bgrft_divmod u_divmod (
    .count_i (load_cnt_q[AddrW-1:0]),
    .cols_i  (eff_cols),
    .pos_o   (ld_pos)
  );

  // Source cell and transformed center.
  always_comb begin
    rows3 = eff_rows[CoordW-1:0];
    cols3 = eff_cols[CoordW-1:0];
    swap  = (mode_q == bgrft_pkg::MODE_TRANSPOSE) || (mode_q == bgrft_pkg::MODE_ROT90) ||
            (mode_q == bgrft_pkg::MODE_ROT270);
    o_rows = swap ? eff_cols : eff_rows;
    o_cols = swap ? eff_rows : eff_cols;
    src_r  = {1'b0, r_q};
    src_c  = {1'b0, c_q};
    cen_x  = cen_col_q;
    cen_y  = cen_row_q;
    case (mode_q)
      bgrft_pkg::MODE_FLIP: begin
        src_r = eff_rows - DimW'(1) - {1'b0, r_q};
        cen_y = rows3 - cen_row_q - CoordW'(1);
      end
      bgrft_pkg::MODE_MIRROR: begin
        src_c = eff_cols - DimW'(1) - {1'b0, c_q};
        cen_x = cols3 - cen_col_q - CoordW'(1);
      end
      bgrft_pkg::MODE_TRANSPOSE: begin
        src_r = {1'b0, c_q};
        src_c = {1'b0, r_q};
        cen_x = cen_row_q;
        cen_y = cen_col_q;
      end
      bgrft_pkg::MODE_ROT90: begin
        src_r = eff_rows - DimW'(1) - {1'b0, c_q};
        src_c = {1'b0, r_q};
        cen_x = rows3 - cen_row_q - CoordW'(1);
        cen_y = cen_col_q;
      end
      bgrft_pkg::MODE_ROT180: begin
        src_r = eff_rows - DimW'(1) - {1'b0, r_q};
        src_c = eff_cols - DimW'(1) - {1'b0, c_q};
        cen_x = cols3 - cen_col_q - CoordW'(1);
        cen_y = rows3 - cen_row_q - CoordW'(1);
      end
      bgrft_pkg::MODE_ROT270: begin
        src_r = {1'b0, c_q};
        src_c = eff_cols - DimW'(1) - {1'b0, r_q};
        cen_x = cen_row_q;
        cen_y = cols3 - cen_col_q - CoordW'(1);
      end
      default: ;
    endcase
    src_idx  = IdxW'(src_r) * IdxW'(eff_cols) + IdxW'(src_c);
    // cells past the fill count were never loaded in this run
    src_hit  = src_idx < IdxW'(load_cnt_q);
    last_col = ({1'b0, c_q} == o_cols - DimW'(1));
    last_row = ({1'b0, r_q} == o_rows - DimW'(1));
  end

  assign final_cell = last_col && last_row;
  assign out_take   = out_valid_q && !out_stall_i;
  assign fetch      = (state_q == bgrft_pkg::ST_EMIT) && more_q && (!out_valid_q || !out_stall_i);

  always_comb begin
    state_d     = state_q;
    load_cnt_d  = load_cnt_q;
    cen_row_d   = cen_row_q;
    cen_col_d   = cen_col_q;
    r_d         = r_q;
    c_d         = c_q;
    more_d      = more_q;
    out_valid_d = out_valid_q;
    case (state_q)
      bgrft_pkg::ST_LOAD: begin
        if (load_wr) begin
          load_cnt_d = load_cnt_q + CountW'(1);
          if (cell_code_i[1]) begin
            cen_row_d = ld_pos.row;
            cen_col_d = ld_pos.col;
          end
        end
        if (in_take && last_cell_i) begin
          state_d = bgrft_pkg::ST_EMIT;
          r_d     = '0;
          c_d     = '0;
          more_d  = 1'b1;
        end
      end
      bgrft_pkg::ST_EMIT: begin
        if (fetch) begin
          out_valid_d = 1'b1;
          if (last_col) begin
            c_d = '0;
            r_d = r_q + CoordW'(1);
          end else begin
            c_d = c_q + CoordW'(1);
          end
          if (final_cell) begin
            more_d = 1'b0;
          end
        end else if (out_take) begin
          out_valid_d = 1'b0;
        end
        if (out_take && out_last_q) begin
          // drop the grid: the fill count alone marks it empty
          state_d    = bgrft_pkg::ST_LOAD;
          load_cnt_d = '0;
          cen_row_d  = '0;
          cen_col_d  = '0;
        end
      end
      default: state_d = bgrft_pkg::ST_LOAD;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= bgrft_pkg::ST_LOAD;
      load_cnt_q  <= '0;
      cen_row_q   <= '0;
      cen_col_q   <= '0;
      r_q         <= '0;
      c_q         <= '0;
      more_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      load_cnt_q  <= load_cnt_d;
      cen_row_q   <= cen_row_d;
      cen_col_q   <= cen_col_d;
      r_q         <= r_d;
      c_q         <= c_d;
      more_q      <= more_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fetch) begin
      out_row_q  <= r_q;
      out_col_q  <= c_q;
      out_last_q <= final_cell;
      out_hit_q  <= src_hit;
    end
  end

  // Grid memory: one write and one registered read a cycle.
  always_ff @(posedge clk_i) begin
    if (load_wr) begin
      mem[load_cnt_q[AddrW-1:0]] <= cell_code_i[0];
    end
    if (fetch) begin
      rdata_q <= mem[src_idx[AddrW-1:0]];
    end
  end

  assign out_valid_o   = out_valid_q;
  assign out_bit_o     = rdata_q & out_hit_q;
  assign out_row_o     = out_row_q;
  assign out_col_o     = out_col_q;
  assign center_x_o    = cen_x;
  assign center_y_o    = cen_y;
  assign last_result_o = out_last_q;

endmodule
`default_nettype wire

// ----- rtl/bgrft_checker.sv -----
// Port-level checks of the bit grid transform block, bound to the top level.
`default_nettype none
module bgrft_checker (
  input wire logic                         clk_i,
  input wire logic                         rst_ni,
  input wire logic                         in_valid_i,
  input wire logic                         in_stall_o,
  input wire logic                         last_cell_i,
  input wire logic                         out_valid_o,
  input wire logic                         out_stall_i,
  input wire logic [bgrft_pkg::CoordW-1:0] out_row_o,
  input wire logic [bgrft_pkg::CoordW-1:0] out_col_o,
  input wire logic                         last_result_o
);

  // no load beat while a result is on offer
  a_load_excl_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |-> !out_valid_o)
    else $error("input beat taken while a result is pending");

  // final cell closes the load
  a_last_stalls: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o && last_cell_i) |=> in_stall_o)
    else $error("input not stalled after final cell");

  // results stream without gaps until the final one
  a_no_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_stall_i && !last_result_o) |=> out_valid_o)
    else $error("gap in result stream");

  // loading resumes right after the final result
  a_reopen: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_stall_i && last_result_o) |=> (!in_stall_o && !out_valid_o))
    else $error("load not reopened after final result");

  // a run starts at the origin of the output grid
  a_run_origin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> (out_row_o == '0 && out_col_o == '0))
    else $error("run does not start at row 0, column 0");

endmodule

bind bit_grid_rotate_flip_transpose bgrft_checker u_bgrft_checker (.*);
`default_nettype wire

// ----- dv/tb_bit_grid_rotate_flip_transpose.sv -----
// Self-checking testbench of the bit grid rotate/flip/transpose block.
`timescale 1ns / 100ps
module tb_bit_grid_rotate_flip_transpose;
  import bgrft_pkg::*;

  localparam int unsigned CycleLimit     = 400000;
  localparam int unsigned RandomCells    = 350;
  localparam int unsigned DrainCycles    = 4;
  localparam int unsigned HoldCycles     = 300;
  localparam int unsigned PrintLimit     = 40;
  localparam int unsigned PhaseZeroCells = 120;

  typedef enum logic [CodeW-1:0] {
    CODE_EMPTY      = 2'd0,
    CODE_SET        = 2'd1,
    CODE_CENTER     = 2'd2,
    CODE_SET_CENTER = 2'd3
  } cell_code_e;

  typedef struct packed {
    logic              out_bit;
    logic [CoordW-1:0] row;
    logic [CoordW-1:0] col;
    logic [CoordW-1:0] cx;
    logic [CoordW-1:0] cy;
    logic              last;
  } cell_result_t;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                cfg_valid_i = 1'b0;
  logic                cfg_ready_o;
  logic [CfgIdxW-1:0]  cfg_index_i = '0;
  logic [CfgDataW-1:0] cfg_data_i = '0;
  logic                in_valid_i = 1'b0;
  logic                in_stall_o;
  logic [CodeW-1:0]    cell_code_i = '0;
  logic                last_cell_i = 1'b0;
  logic                out_valid_o;
  logic                out_stall_i = 1'b0;
  logic                out_bit_o;
  logic [CoordW-1:0]   out_row_o;
  logic [CoordW-1:0]   out_col_o;
  logic [CoordW-1:0]   center_x_o;
  logic [CoordW-1:0]   center_y_o;
  logic                last_result_o;

  // Predictor state: register copies and the loaded grid.
  logic [CfgDataW-1:0] reg_rows = CfgDataW'(1);
  logic [CfgDataW-1:0] reg_cols = CfgDataW'(1);
  logic [ModeW-1:0]    reg_mode = MODE_FLIP;
  logic                grid_bits [GridDepth];
  logic [CoordW-1:0]   ctr_row = '0;
  logic [CoordW-1:0]   ctr_col = '0;
  int unsigned         fill_count = 0;

  cell_result_t        expected_cells [$];
  int unsigned         mismatch_count = 0;
  int unsigned         loaded_cells = 0;
  int unsigned         cell_gap_pct = 25;
  int unsigned         sink_stall_pct = 25;
  logic                sink_hold = 1'b0;

  bit_grid_rotate_flip_transpose dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .cell_code_i   (cell_code_i),
    .last_cell_i   (last_cell_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .out_bit_o     (out_bit_o),
    .out_row_o     (out_row_o),
    .out_col_o     (out_col_o),
    .center_x_o    (center_x_o),
    .center_y_o    (center_y_o),
    .last_result_o (last_result_o)
  );

  always #10 clk_i = ~clk_i;

  function automatic int unsigned clamp_dim(input logic [CfgDataW-1:0] v, input int unsigned lim);
    if (v == '0) return 1;
    if (v > lim) return lim;
    return v;
  endfunction

  // Load one cell and, on the final one, queue the transformed grid.
  task automatic predict_cell(input logic [CodeW-1:0] code, input logic last);
    int unsigned  nr, nc, total, orows, ocols, sr, sc, n;
    int           cxi, cyi;
    logic         swap;
    cell_result_t res;
    nr = clamp_dim(reg_rows, MaxRows);
    nc = clamp_dim(reg_cols, MaxCols);
    total = nr * nc;
    if (fill_count < total) begin
      if (code == CODE_SET || code == CODE_SET_CENTER) grid_bits[fill_count] = 1'b1;
      if (code == CODE_CENTER || code == CODE_SET_CENTER) begin
        ctr_row = CoordW'(fill_count / nc);
        ctr_col = CoordW'(fill_count % nc);
      end
      fill_count++;
    end
    if (last) begin
      swap = (reg_mode == MODE_TRANSPOSE || reg_mode == MODE_ROT90 || reg_mode == MODE_ROT270);
      orows = swap ? nc : nr;
      ocols = swap ? nr : nc;
      cxi = ctr_col;
      cyi = ctr_row;
      case (reg_mode)
        MODE_FLIP: cyi = int'(nr) - int'(ctr_row) - 1;
        MODE_MIRROR: cxi = int'(nc) - int'(ctr_col) - 1;
        MODE_TRANSPOSE: begin
          cxi = ctr_row;
          cyi = ctr_col;
        end
        MODE_ROT90: begin
          cxi = int'(nr) - int'(ctr_row) - 1;
          cyi = ctr_col;
        end
        MODE_ROT180: begin
          cxi = int'(nc) - int'(ctr_col) - 1;
          cyi = int'(nr) - int'(ctr_row) - 1;
        end
        MODE_ROT270: begin
          cxi = ctr_row;
          cyi = int'(nc) - int'(ctr_col) - 1;
        end
        default: ;
      endcase
      n = 0;
      for (int unsigned r = 0; r < orows; r++) begin
        for (int unsigned c = 0; c < ocols; c++) begin
          sr = r;
          sc = c;
          case (reg_mode)
            MODE_FLIP: sr = nr - 1 - r;
            MODE_MIRROR: sc = nc - 1 - c;
            MODE_TRANSPOSE: begin
              sr = c;
              sc = r;
            end
            MODE_ROT90: begin
              sr = nr - 1 - c;
              sc = r;
            end
            MODE_ROT180: begin
              sr = nr - 1 - r;
              sc = nc - 1 - c;
            end
            MODE_ROT270: begin
              sr = c;
              sc = nc - 1 - r;
            end
            default: ;
          endcase
          res.out_bit = grid_bits[sr * nc + sc];
          res.row = CoordW'(r);
          res.col = CoordW'(c);
          res.cx = CoordW'(cxi);
          res.cy = CoordW'(cyi);
          res.last = (n + 1 == total);
          expected_cells.push_back(res);
          n++;
        end
      end
      foreach (grid_bits[i]) grid_bits[i] = 1'b0;
      ctr_row = '0;
      ctr_col = '0;
      fill_count = 0;
    end
  endtask

  task automatic report_mismatch(input string msg);
    mismatch_count++;
    if (mismatch_count <= PrintLimit) $display("mismatch at %0t: %s", $realtime, msg);
  endtask

  task automatic check_field(input string name, input int got, input int want);
    if (got != want) report_mismatch($sformatf("%s got %0d want %0d", name, got, want));
  endtask

  task automatic check_result();
    cell_result_t want;
    if (expected_cells.size() == 0) begin
      report_mismatch("result beat with nothing expected");
    end else begin
      want = expected_cells.pop_front();
      check_field("out_bit", out_bit_o, want.out_bit);
      check_field("out_row", out_row_o, want.row);
      check_field("out_col", out_col_o, want.col);
      check_field("center_x", center_x_o, want.cx);
      check_field("center_y", center_y_o, want.cy);
      check_field("last_result", last_result_o, want.last);
    end
  endtask

  // Sink: take result beats and stall at random or while held off.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) check_result();
      out_stall_i <= sink_hold || ($urandom_range(99) < sink_stall_pct);
    end
  end

  initial begin
    for (int unsigned k = 0; k < CycleLimit; k++) @(posedge clk_i);
    $display("timeout after %0d cycles", CycleLimit);
    $display("tb_bit_grid_rotate_flip_transpose: FAIL");
    $finish;
  end

  task automatic hold_sink(input int unsigned cycles);
    sink_hold <= 1'b1;
    repeat (cycles) @(posedge clk_i);
    sink_hold <= 1'b0;
  endtask

  // Leave valid high on return so back-to-back beats need no gap.
  task automatic send_cell(input cell_code_e code, input logic last);
    while ($urandom_range(99) < cell_gap_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    cell_code_i <= code;
    last_cell_i <= last;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    predict_cell(code, last);
  endtask

  // Drop valid and wait out every pending result plus the load latency.
  task automatic settle();
    in_valid_i <= 1'b0;
    while (expected_cells.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic write_reg(input cfg_idx_e idx, input logic [CfgDataW-1:0] value);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= value;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    case (idx)
      CFG_ROWS: reg_rows = value;
      CFG_COLS: reg_cols = value;
      default:  reg_mode = value[ModeW-1:0];
    endcase
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  function automatic cell_code_e random_code();
    logic [CodeW-1:0] v;
    v = CodeW'($urandom_range(1));
    if ($urandom_range(99) < 15) v[1] = 1'b1;
    return cell_code_e'(v);
  endfunction

  function automatic logic [CfgDataW-1:0] random_dim(input int unsigned lim);
    int unsigned p;
    p = $urandom_range(99);
    if (p < 70) return CfgDataW'($urandom_range(1, 4));
    if (p < 80) return CfgDataW'(lim);
    if (p < 88) return CfgDataW'($urandom_range(lim - 3, lim - 1));
    return CfgDataW'($urandom_range((1 << CfgDataW) - 1));
  endfunction

  task automatic pick_geometry();
    write_reg(CFG_ROWS, random_dim(MaxRows));
    write_reg(CFG_COLS, random_dim(MaxCols));
    if ($urandom_range(99) < 10) begin
      write_reg(CFG_MODE, CfgDataW'($urandom_range((1 << CfgDataW) - 1)));
    end else begin
      write_reg(CFG_MODE, CfgDataW'($urandom_range((1 << ModeW) - 1)));
    end
  endtask

  // Mostly exact loads, some short, some with excess cells.
  task automatic send_random_grid();
    int unsigned total, len, p;
    total = clamp_dim(reg_rows, MaxRows) * clamp_dim(reg_cols, MaxCols);
    p = $urandom_range(99);
    if (p < 70 || total == 1) len = total;
    else if (p < 85) len = $urandom_range(1, total - 1);
    else len = total + $urandom_range(1, 3);
    if (p >= 85 && total == 1) len = total + $urandom_range(1, 3);
    for (int unsigned k = 0; k < len; k++) begin
      send_cell(random_code(), k == len - 1);
      if (k < total) loaded_cells++;
    end
  endtask

  task automatic test_reset_state();
    send_cell(CODE_SET_CENTER, 1'b1);
  endtask

  // Non-square short load under every mode code, the unused ones too.
  task automatic test_each_mode();
    settle();
    write_reg(CFG_ROWS, CfgDataW'(2));
    write_reg(CFG_COLS, CfgDataW'(3));
    for (int unsigned m = 0; m < (1 << ModeW); m++) begin
      settle();
      write_reg(CFG_MODE, CfgDataW'(m));
      send_cell(CODE_SET, 1'b0);
      send_cell(CODE_SET_CENTER, 1'b1);
    end
  endtask

  // Zero dimensions act as one; later center marks fall beyond the grid.
  task automatic test_excess_cells();
    settle();
    write_reg(CFG_ROWS, '0);
    write_reg(CFG_COLS, '0);
    write_reg(CFG_MODE, CfgDataW'(MODE_MIRROR));
    send_cell(CODE_SET, 1'b0);
    send_cell(CODE_CENTER, 1'b0);
    send_cell(CODE_SET_CENTER, 1'b1);
  endtask

  // Shrink the grid mid-load so the stored center wraps on emission.
  task automatic test_resize_mid_load();
    settle();
    write_reg(CFG_ROWS, CfgDataW'(2));
    write_reg(CFG_COLS, CfgDataW'(2));
    write_reg(CFG_MODE, CfgDataW'(MODE_ROT180));
    repeat (3) send_cell(CODE_CENTER, 1'b0);
    settle();
    write_reg(CFG_ROWS, CfgDataW'(1));
    write_reg(CFG_COLS, CfgDataW'(1));
    send_cell(CODE_EMPTY, 1'b1);
  endtask

  // Oversized dimensions clamp to the full grid.
  task automatic test_largest_grid();
    settle();
    write_reg(CFG_ROWS, '1);
    write_reg(CFG_COLS, CfgDataW'(MaxCols + 1));
    write_reg(CFG_MODE, CfgDataW'(MODE_ROT90));
    send_cell(CODE_SET_CENTER, 1'b1);
  endtask

  task automatic test_random_grids();
    int unsigned phase, grids, start;
    logic        more;
    phase = 0;
    while (loaded_cells < RandomCells || phase < 3) begin
      settle();
      cell_gap_pct <= (phase == 0) ? 0 : 25;
      sink_stall_pct <= (phase == 0) ? 0 : 25;
      pick_geometry();
      if (phase == 2) begin
        fork
          hold_sink(HoldCycles);
        join_none
      end
      grids = (phase == 0) ? 12 : $urandom_range(2, 5);
      start = loaded_cells;
      for (int unsigned g = 0; g < grids; g++) begin
        // cap the idle-free stretch at PhaseZeroCells loaded cells
        if (phase == 0) more = (loaded_cells - start < PhaseZeroCells);
        else more = (phase < 3 || loaded_cells < RandomCells);
        if (more) send_random_grid();
      end
      phase++;
    end
  endtask

  initial begin
    foreach (grid_bits[i]) grid_bits[i] = 1'b0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_state();
    test_each_mode();
    test_excess_cells();
    test_resize_mid_load();
    test_largest_grid();
    test_random_grids();
    settle();
    repeat (8) @(posedge clk_i);
    if (mismatch_count == 0 && expected_cells.size() == 0) begin
      $display("tb_bit_grid_rotate_flip_transpose: PASS");
    end else begin
      $display("tb_bit_grid_rotate_flip_transpose: FAIL");
    end
    $finish;
  end

endmodule
